@@ rtl/swpr_pkg.sv @@
// ----------------------------------------------------------------------------
// swpr_pkg
// Shared types, constants and helpers of the stop-and-wait packet receiver.
// ----------------------------------------------------------------------------
package swpr_pkg;

	localparam int MAX_DATAGRAM_BYTES = 4096;
	localparam int HDR_BYTES = 8;
	localparam int POS_W = 17;
	localparam int PLEN_W = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [POS_W-1:0] HDR_LEN = POS_W'(HDR_BYTES);
	localparam logic [POS_W-1:0] PAYLOAD_CAP = POS_W'(MAX_DATAGRAM_BYTES - HDR_BYTES);
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [15:0] LOCAL_PORT_RESET = 16'd6666;
	localparam logic [15:0] SUM_GOOD = 16'hFFFF;
	localparam logic [15:0] ACK_LENGTH = 16'h0003;
	localparam logic [7:0] ACK_CHAR_A = 8'h41;
	localparam logic [7:0] ACK_CHAR_C = 8'h43;
	localparam logic [7:0] ACK_CHAR_K = 8'h4B;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_VERDICT = 2'd1;
	localparam logic [1:0] KIND_ACK = 2'd2;

	localparam logic [CFG_ADDR_W-3:0] REG_LOCAL_PORT = '0;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [7:0]        out_byte;
		logic              accepted;
		logic [PLEN_W-1:0] payload_length;
		logic              out_last;
	} result_t;

	typedef struct packed {
		logic              has_payload;
		logic [7:0]        payload_byte;
		logic              has_verdict;
		logic              accepted;
		logic [PLEN_W-1:0] payload_length;
		logic [15:0]       ack_seq;
	} job_t;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

@@ rtl/swpr_front.sv @@
// ----------------------------------------------------------------------------
// swpr_front
// Parses the datagram header, keeps the running checksum and turns each
// accepted payload byte and each last word into a job for the output side.
// ----------------------------------------------------------------------------
module swpr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  swpr_pkg::item_t     item,
	input  logic                q_full,
	output logic                push,
	output swpr_pkg::job_t      job
);

	localparam logic [swpr_pkg::POS_W-1:0] POS_SEQ_HI = swpr_pkg::POS_W'(2);
	localparam logic [swpr_pkg::POS_W-1:0] POS_SEQ_LO = swpr_pkg::POS_W'(3);
	localparam logic [swpr_pkg::POS_W-1:0] POS_LEN_HI = swpr_pkg::POS_W'(4);
	localparam logic [swpr_pkg::POS_W-1:0] POS_LEN_LO = swpr_pkg::POS_W'(5);

	logic [swpr_pkg::POS_W-1:0] pos_q, pos_n;
	logic [15:0] sum_q, seq_q, len_q, exp_q;
	logic [7:0]  pend_q;
	logic        half_q;

	logic        fire, in_body, emit_payload, hdr_ok, full, fits, acc;
	logic [swpr_pkg::POS_W-1:0] body_end, kept, len_ext_n, kept_n;
	logic [15:0] seq_n, len_n, word, sum_add, ack_seq;
	logic [swpr_pkg::PLEN_W-1:0] plen;

	assign item_ready = !q_full;
	assign fire = item_valid && item_ready;

	always_comb begin
		body_end = {1'b0, len_q} + swpr_pkg::HDR_LEN;
		in_body = pos_q < body_end;
		kept = ({1'b0, len_q} < swpr_pkg::PAYLOAD_CAP) ? {1'b0, len_q} : swpr_pkg::PAYLOAD_CAP;
		emit_payload = (pos_q >= swpr_pkg::HDR_LEN) && (pos_q < kept + swpr_pkg::HDR_LEN);

		seq_n = seq_q;
		len_n = len_q;
		if (in_body) begin
			if (pos_q == POS_SEQ_HI) seq_n = {item.in_byte, 8'h00};
			if (pos_q == POS_SEQ_LO) seq_n = seq_q | {8'h00, item.in_byte};
			if (pos_q == POS_LEN_HI) len_n = {item.in_byte, 8'h00};
			if (pos_q == POS_LEN_LO) len_n = len_q | {8'h00, item.in_byte};
		end

		if (in_body) begin
			word = pos_q[0] ? {pend_q, item.in_byte} : {item.in_byte, 8'h00};
		end else begin
			word = half_q ? {pend_q, 8'h00} : 16'h0000;
		end
		sum_add = swpr_pkg::ones_add(sum_q, word);

		pos_n = (pos_q == swpr_pkg::POS_MAX) ? pos_q : pos_q + swpr_pkg::POS_W'(1);
		len_ext_n = {1'b0, len_n};
		hdr_ok = pos_n >= swpr_pkg::HDR_LEN;
		full = pos_n >= len_ext_n + swpr_pkg::HDR_LEN;
		fits = len_ext_n <= swpr_pkg::PAYLOAD_CAP;
		acc = hdr_ok && full && fits && (sum_add == swpr_pkg::SUM_GOOD) && (seq_n == exp_q);
		kept_n = (len_ext_n < swpr_pkg::PAYLOAD_CAP) ? len_ext_n : swpr_pkg::PAYLOAD_CAP;
		plen = hdr_ok ? kept_n[swpr_pkg::PLEN_W-1:0] : '0;
		ack_seq = acc ? seq_n : exp_q - 16'd1;

		push = fire && (emit_payload || item.in_last);
		job.has_payload = emit_payload;
		job.payload_byte = item.in_byte;
		job.has_verdict = item.in_last;
		job.accepted = acc;
		job.payload_length = plen;
		job.ack_seq = ack_seq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			pend_q <= '0;
			half_q <= 1'b0;
			seq_q <= '0;
			len_q <= '0;
			exp_q <= '0;
		end else if (fire) begin
			if (item.in_last) begin
				pos_q <= '0;
				sum_q <= '0;
				pend_q <= '0;
				half_q <= 1'b0;
				seq_q <= '0;
				len_q <= '0;
				if (acc) exp_q <= exp_q + 16'd1;
			end else begin
				pos_q <= pos_n;
				seq_q <= seq_n;
				len_q <= len_n;
				if (in_body) begin
					if (pos_q[0]) begin
						sum_q <= sum_add;
						half_q <= 1'b0;
					end else begin
						pend_q <= item.in_byte;
						half_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

@@ rtl/swpr_fifo.sv @@
// ----------------------------------------------------------------------------
// swpr_fifo
// Short job queue that decouples header parsing from result generation.
// ----------------------------------------------------------------------------
module swpr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  swpr_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output swpr_pkg::job_t  head_job
);

	localparam int PTR_W = $clog2(swpr_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(swpr_pkg::QUEUE_DEPTH + 1);

	swpr_pkg::job_t mem_q [swpr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full = count_q == CNT_W'(swpr_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

@@ rtl/swpr_back.sv @@
// ----------------------------------------------------------------------------
// swpr_back
// Expands each job into its payload word, if it has one, and for a last word
// its verdict and ACK packet words, and holds them in the output register.
// ----------------------------------------------------------------------------
module swpr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       local_port,
	input  logic              head_valid,
	input  swpr_pkg::job_t    head_job,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output swpr_pkg::result_t result
);

	localparam logic [3:0] PH_PAYLOAD = 4'd0;
	localparam logic [3:0] PH_VERDICT = 4'd1;
	localparam logic [3:0] PH_ACK_FIRST = 4'd2;
	localparam logic [3:0] PH_ACK_LAST = 4'd12;

	swpr_pkg::job_t    cur_q;
	logic              cur_valid_q;
	logic [3:0]        phase_q;
	swpr_pkg::result_t res_q;
	logic              res_valid_q;

	logic              adv, done;
	logic [3:0]        ack_idx;
	logic [17:0]       cs_raw;
	logic [16:0]       cs_fold1;
	logic [15:0]       cs_fold2, cs;
	swpr_pkg::result_t res_n;

	assign adv = cur_valid_q && (!res_valid_q || result_ready);
	assign done = adv && ((phase_q == PH_PAYLOAD) ? !cur_q.has_verdict : (phase_q == PH_ACK_LAST));
	assign pop = head_valid && (!cur_valid_q || done);
	assign result_valid = res_valid_q;
	assign result = res_q;

	always_comb begin
		cs_raw = {2'b00, local_port} + {2'b00, cur_q.ack_seq}
			+ {2'b00, swpr_pkg::ACK_LENGTH}
			+ {2'b00, swpr_pkg::ACK_CHAR_A, swpr_pkg::ACK_CHAR_C}
			+ {2'b00, swpr_pkg::ACK_CHAR_K, 8'h00};
		cs_fold1 = {1'b0, cs_raw[15:0]} + {15'd0, cs_raw[17:16]};
		cs_fold2 = cs_fold1[15:0] + {15'd0, cs_fold1[16]};
		cs = ~cs_fold2;

		ack_idx = phase_q - PH_ACK_FIRST;
		res_n = '0;
		if (phase_q == PH_PAYLOAD) begin
			res_n.result_kind = swpr_pkg::KIND_PAYLOAD;
			res_n.out_byte = cur_q.payload_byte;
		end else if (phase_q == PH_VERDICT) begin
			res_n.result_kind = swpr_pkg::KIND_VERDICT;
			res_n.accepted = cur_q.accepted;
			res_n.payload_length = cur_q.payload_length;
		end else begin
			res_n.result_kind = swpr_pkg::KIND_ACK;
			res_n.out_last = phase_q == PH_ACK_LAST;
			case (ack_idx)
				4'd0:    res_n.out_byte = local_port[15:8];
				4'd1:    res_n.out_byte = local_port[7:0];
				4'd2:    res_n.out_byte = cur_q.ack_seq[15:8];
				4'd3:    res_n.out_byte = cur_q.ack_seq[7:0];
				4'd4:    res_n.out_byte = swpr_pkg::ACK_LENGTH[15:8];
				4'd5:    res_n.out_byte = swpr_pkg::ACK_LENGTH[7:0];
				4'd6:    res_n.out_byte = cs[15:8];
				4'd7:    res_n.out_byte = cs[7:0];
				4'd8:    res_n.out_byte = swpr_pkg::ACK_CHAR_A;
				4'd9:    res_n.out_byte = swpr_pkg::ACK_CHAR_C;
				4'd10:   res_n.out_byte = swpr_pkg::ACK_CHAR_K;
				default: res_n.out_byte = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head_job;
		if (adv) res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q <= PH_PAYLOAD;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				phase_q <= head_job.has_payload ? PH_PAYLOAD : PH_VERDICT;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end else if (adv) begin
				phase_q <= (phase_q == PH_PAYLOAD) ? PH_VERDICT : phase_q + 4'd1;
			end

			if (adv) res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/stop_wait_packet_receiver_core.sv @@
// ----------------------------------------------------------------------------
// stop_wait_packet_receiver_core
// Stop-and-wait receiver: checks incoming datagrams and answers with ACKs.
// ----------------------------------------------------------------------------
// Datagram words enter on the item channel, one byte each, the last flagged.
// Results leave on the result channel: payload bytes marked tentative, then
// one verdict word at the end of each datagram, then the 11 words of the ACK.
// The input side takes one word per cycle while the four-entry job queue has
// room. A payload word passes the job queue, the current-job register and
// the output register. The last word of a datagram expands into 12 result
// words, or 13 when it is also a payload byte, so the result port, at one
// word per cycle unless stalled, sets the rate while an ACK drains: the
// queue then fills and the input side stalls until it has room again.
// A stall on the result side holds the output register and lets the queue
// fill before the input side stalls. Reset clears the expected sequence
// number, the header parser, the queue and the output valid flag, and sets the
// local port to 6666. The local port is written through the APB port at
// byte address 0; it is read back from the same address.
// ----------------------------------------------------------------------------
module stop_wait_packet_receiver_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  swpr_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output swpr_pkg::result_t                   result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swpr_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [swpr_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [swpr_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);

	logic [15:0]    local_port_q;
	logic           q_full, push, pop, head_valid;
	swpr_pkg::job_t push_job, head_job;
	logic           reg_hit;

	assign pready = 1'b1;
	assign reg_hit = paddr[swpr_pkg::CFG_ADDR_W-1:2] == swpr_pkg::REG_LOCAL_PORT;
	assign prdata = reg_hit ? {16'h0000, local_port_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_port_q <= swpr_pkg::LOCAL_PORT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			local_port_q <= pwdata[15:0];
		end
	end

	swpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.job        (push_job)
	);

	swpr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	swpr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.local_port   (local_port_q),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ tb/stop_wait_packet_receiver_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stop_wait_packet_receiver_core_tb
// Self-checking bench for the stop-and-wait packet receiver. A table of
// datagrams covers empty, odd, all-zero and all-one payloads, bad checksums,
// duplicate and foreign sequence numbers, extra and missing bytes, short
// headers and over-capacity lengths.
// Random datagrams follow, mostly well formed, under several local port
// settings, with random idle cycles on both channels and one long result
// stall. Every result word is checked against a behavioral model.
// ----------------------------------------------------------------------------
module stop_wait_packet_receiver_core_tb;

	localparam int CAP = swpr_pkg::MAX_DATAGRAM_BYTES - swpr_pkg::HDR_BYTES;
	localparam int unsigned POS_SAT = 32'h7FFF_FFFF;
	localparam int LIMIT = 2000000;
	localparam int LONG_STALL = 300;
	localparam int ROWS = 13;

	typedef enum logic [1:0] {SEQ_NEXT, SEQ_PREV, SEQ_FIXED} seq_pick_t;
	typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct packed {
		seq_pick_t   seq_pick;
		logic [15:0] seq_fixed;
		logic [15:0] len_field;
		logic [15:0] body_bytes;
		logic [15:0] sent_bytes;
		logic        cs_good;
		fill_t       fill;
		logic        typed;
		logic        t_acc;
		logic [11:0] t_plen;
	} dgram_plan_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	swpr_pkg::item_t item;
	logic result_valid;
	logic result_ready;
	swpr_pkg::result_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [swpr_pkg::CFG_ADDR_W-1:0] paddr;
	logic [swpr_pkg::CFG_DATA_W-1:0] pwdata;
	logic [swpr_pkg::CFG_DATA_W-1:0] prdata;
	logic pready;

	logic [15:0] port_reg;
	logic [15:0] next_seq;
	int unsigned rx_pos;
	logic [15:0] rx_sum;
	logic [7:0] rx_high;
	bit rx_half;
	logic [15:0] rx_seq;
	logic [15:0] rx_len;

	swpr_pkg::result_t due_words [$];
	int words_sent;
	int words_checked;
	int mismatches;
	int dgrams;
	int dgrams_ok;
	int port_settings;
	int cycle_count;
	bit idle_on;
	bit long_stall_req;

	stop_wait_packet_receiver_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] fold16(input logic [15:0] a, input logic [15:0] b);
		int unsigned t;
		t = a + b;
		t = (t >> 16) + (t & 32'hFFFF);
		return t[15:0];
	endfunction

	function automatic swpr_pkg::result_t make_word(input logic [1:0] kind,
			input logic [7:0] b, input logic acc, input logic [11:0] plen,
			input logic last);
		swpr_pkg::result_t r;
		r.result_kind = kind;
		r.out_byte = b;
		r.accepted = acc;
		r.payload_length = plen;
		r.out_last = last;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	task automatic predict_byte(input swpr_pkg::item_t w);
		int unsigned p;
		int unsigned lim;
		int unsigned kept;
		logic [15:0] s;
		logic [15:0] ack_seq;
		logic [15:0] ack_cs;
		logic [7:0] ack [0:10];
		bit ok;
		int i;
		p = rx_pos;
		lim = swpr_pkg::HDR_BYTES + rx_len;
		kept = (rx_len < CAP) ? rx_len : CAP;
		if (p < lim) begin
			case (p)
				2: rx_seq[15:8] = w.in_byte;
				3: rx_seq[7:0] = w.in_byte;
				4: rx_len[15:8] = w.in_byte;
				5: rx_len[7:0] = w.in_byte;
				default: ;
			endcase
			if ((p & 1) == 0) begin
				rx_high = w.in_byte;
				rx_half = 1'b1;
			end else begin
				rx_sum = fold16(rx_sum, {rx_high, w.in_byte});
				rx_half = 1'b0;
			end
		end
		if (p >= swpr_pkg::HDR_BYTES && p < swpr_pkg::HDR_BYTES + kept)
			due_words.push_back(make_word(swpr_pkg::KIND_PAYLOAD, w.in_byte, 1'b0, '0,
				1'b0));
		if (p < POS_SAT)
			p++;
		rx_pos = p;
		if (w.in_last) begin
			s = rx_half ? fold16(rx_sum, {rx_high, 8'h00}) : rx_sum;
			ok = p >= swpr_pkg::HDR_BYTES && p >= swpr_pkg::HDR_BYTES + rx_len &&
				rx_len <= CAP && s == 16'hFFFF && rx_seq == next_seq;
			due_words.push_back(make_word(swpr_pkg::KIND_VERDICT, 8'h00, ok,
				(p >= swpr_pkg::HDR_BYTES) ?
				((rx_len < CAP) ? rx_len[11:0] : 12'(CAP)) : 12'd0,
				1'b0));
			dgrams++;
			if (ok) begin
				ack_seq = rx_seq;
				next_seq = next_seq + 16'd1;
				dgrams_ok++;
			end else begin
				ack_seq = next_seq - 16'd1;
			end
			ack[0] = port_reg[15:8];
			ack[1] = port_reg[7:0];
			ack[2] = ack_seq[15:8];
			ack[3] = ack_seq[7:0];
			ack[4] = 8'h00;
			ack[5] = 8'h03;
			ack[6] = 8'h00;
			ack[7] = 8'h00;
			ack[8] = "A";
			ack[9] = "C";
			ack[10] = "K";
			ack_cs = 16'h0000;
			for (i = 0; i < 10; i += 2)
				ack_cs = fold16(ack_cs, {ack[i], ack[i + 1]});
			ack_cs = ~fold16(ack_cs, {ack[10], 8'h00});
			ack[6] = ack_cs[15:8];
			ack[7] = ack_cs[7:0];
			for (i = 0; i < 11; i++)
				due_words.push_back(make_word(swpr_pkg::KIND_ACK, ack[i], 1'b0, '0,
					i == 10));
			rx_pos = 0;
			rx_sum = '0;
			rx_high = '0;
			rx_half = 1'b0;
			rx_seq = '0;
			rx_len = '0;
		end
	endtask

	task automatic send_word(input swpr_pkg::item_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		predict_byte(w);
		words_sent++;
	endtask

	task automatic send_datagram(input dgram_plan_t d);
		logic [7:0] img [$];
		logic [15:0] seq;
		logic [15:0] port_in;
		logic [15:0] sum;
		logic [15:0] cs;
		logic [7:0] lo;
		swpr_pkg::result_t v;
		swpr_pkg::item_t w;
		int lim;
		int total;
		int i;
		case (d.seq_pick)
			SEQ_NEXT: seq = next_seq;
			SEQ_PREV: seq = next_seq - 16'd1;
			default: seq = d.seq_fixed;
		endcase
		port_in = 16'($urandom);
		img = {port_in[15:8], port_in[7:0], seq[15:8], seq[7:0],
			d.len_field[15:8], d.len_field[7:0], 8'h00, 8'h00};
		for (i = 0; i < d.body_bytes; i++) begin
			case (d.fill)
				FILL_ZERO: img.push_back(8'h00);
				FILL_ONES: img.push_back(8'hFF);
				default: img.push_back(8'($urandom));
			endcase
		end
		lim = swpr_pkg::HDR_BYTES + int'(d.len_field);
		sum = 16'h0000;
		for (i = 0; i < lim && i < img.size(); i += 2) begin
			lo = (i + 1 < lim && i + 1 < img.size()) ? img[i + 1] : 8'h00;
			sum = fold16(sum, {img[i], lo});
		end
		cs = d.cs_good ? ~sum : (~sum ^ 16'h0001);
		img[6] = cs[15:8];
		img[7] = cs[7:0];
		total = (d.sent_bytes == 0) ? img.size() : int'(d.sent_bytes);
		for (i = 0; i < total; i++) begin
			w.in_byte = img[i];
			w.in_last = (i == total - 1);
			send_word(w);
		end
		if (d.typed) begin
			v = due_words[due_words.size() - 12];
			v.accepted = d.t_acc;
			v.payload_length = d.t_plen;
			due_words[due_words.size() - 12] = v;
		end
	endtask

	task automatic send_random_datagram();
		dgram_plan_t d;
		int r;
		int len;
		r = $urandom_range(0, 99);
		len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 16) : $urandom_range(17, 48);
		d = '0;
		d.seq_pick = SEQ_NEXT;
		d.fill = FILL_RAND;
		d.cs_good = 1'b1;
		d.body_bytes = 16'(len);
		if (r < 8) begin
			d.seq_pick = SEQ_PREV;
		end else if (r < 12) begin
			d.seq_pick = SEQ_FIXED;
			d.seq_fixed = 16'($urandom);
		end else if (r < 20) begin
			d.cs_good = 1'b0;
		end else if (r < 25) begin
			d.body_bytes = 16'(len + $urandom_range(1, 6));
		end else if (r < 29 && len > 0) begin
			d.body_bytes = 16'($urandom_range(0, len - 1));
		end else if (r < 33) begin
			d.sent_bytes = 16'($urandom_range(1, 7));
		end else if (r < 36) begin
			len = $urandom_range(CAP + 1, 65535);
			d.body_bytes = 16'($urandom_range(0, 6));
		end
		d.len_field = 16'(len);
		send_datagram(d);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic apb_write(input logic [swpr_pkg::CFG_ADDR_W-1:0] a,
			input logic [swpr_pkg::CFG_DATA_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic report_mismatch(input string what, input swpr_pkg::result_t want,
			input swpr_pkg::result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: want kind %0d byte %02h acc %0b len %0d last %0b, %s",
				what, want.result_kind, want.out_byte, want.accepted,
				want.payload_length, want.out_last,
				$sformatf("got kind %0d byte %02h acc %0b len %0d last %0b",
				got.result_kind, got.out_byte, got.accepted,
				got.payload_length, got.out_last));
	endtask

	always @(posedge clk) begin : check_words
		swpr_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			words_checked++;
			if (due_words.size() == 0) begin
				report_mismatch("word with none due", '0, result);
			end else begin
				want = due_words.pop_front();
				if (result.result_kind !== want.result_kind ||
						result.out_byte !== want.out_byte ||
						result.accepted !== want.accepted ||
						result.payload_length !== want.payload_length ||
						result.out_last !== want.out_last)
					report_mismatch("word differs", want, result);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("stop_wait_packet_receiver_core: mismatch");
			$finish;
		end
	end

	initial begin
		int stall_left;
		int g;
		stall_left = 0;
		result_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if (long_stall_req) begin
				long_stall_req = 1'b0;
				result_ready <= 1'b0;
				stall_left = LONG_STALL - 1;
			end else begin
				g = pick_gap();
				if (g > 0) begin
					result_ready <= 1'b0;
					stall_left = g - 1;
				end else begin
					result_ready <= 1'b1;
				end
			end
			@(posedge clk);
		end
	end

	initial begin
		dgram_plan_t plan [ROWS];
		logic [15:0] port_val;
		int phase_end;
		int k;
		plan = '{
			'{SEQ_NEXT, 16'h0000, 16'd2, 16'd2, 16'd5, 1'b1, FILL_RAND, 1'b1, 1'b0, 12'd0},
			'{SEQ_NEXT, 16'h0000, 16'd2, 16'd2, 16'd1, 1'b1, FILL_RAND, 1'b1, 1'b0, 12'd0},
			'{SEQ_NEXT, 16'h0000, 16'd0, 16'd0, 16'd0, 1'b1, FILL_RAND, 1'b1, 1'b1, 12'd0},
			'{SEQ_NEXT, 16'h0000, 16'd1, 16'd1, 16'd0, 1'b1, FILL_RAND, 1'b1, 1'b1, 12'd1},
			'{SEQ_NEXT, 16'h0000, 16'd4, 16'd4, 16'd0, 1'b1, FILL_ONES, 1'b1, 1'b1, 12'd4},
			'{SEQ_NEXT, 16'h0000, 16'd6, 16'd6, 16'd0, 1'b1, FILL_ZERO, 1'b1, 1'b1, 12'd6},
			'{SEQ_NEXT, 16'h0000, 16'd5, 16'd5, 16'd0, 1'b0, FILL_RAND, 1'b1, 1'b0, 12'd5},
			'{SEQ_PREV, 16'h0000, 16'd3, 16'd3, 16'd0, 1'b1, FILL_RAND, 1'b1, 1'b0, 12'd3},
			'{SEQ_NEXT, 16'h0000, 16'd6, 16'd9, 16'd0, 1'b1, FILL_RAND, 1'b1, 1'b1, 12'd6},
			'{SEQ_NEXT, 16'h0000, 16'd10, 16'd4, 16'd0, 1'b1, FILL_RAND, 1'b1, 1'b0, 12'd10},
			'{SEQ_FIXED, 16'hFFFF, 16'd2, 16'd2, 16'd0, 1'b1, FILL_RAND, 1'b1, 1'b0, 12'd2},
			'{SEQ_NEXT, 16'h0000, 16'hFFFF, 16'd2, 16'd0, 1'b1, FILL_RAND, 1'b1, 1'b0,
				12'd4088},
			'{SEQ_NEXT, 16'h0000, 16'd7, 16'd7, 16'd0, 1'b1, FILL_RAND, 1'b0, 1'b0, 12'd0}
		};
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		port_reg = swpr_pkg::LOCAL_PORT_RESET;
		next_seq = '0;
		rx_pos = 0;
		rx_sum = '0;
		rx_high = '0;
		rx_half = 1'b0;
		rx_seq = '0;
		rx_len = '0;
		words_sent = 0;
		words_checked = 0;
		mismatches = 0;
		dgrams = 0;
		dgrams_ok = 0;
		port_settings = 1;
		cycle_count = 0;
		idle_on = 1'b1;
		long_stall_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < ROWS; k++)
			send_datagram(plan[k]);
		drain();

		for (k = 0; k < 4; k++) begin
			if (k == 0)
				port_val = 16'h0000;
			else if (k == 1)
				port_val = 16'hFFFF;
			else
				port_val = 16'($urandom);
			apb_write({swpr_pkg::REG_LOCAL_PORT, 2'b00}, {16'($urandom), port_val});
			port_reg = port_val;
			port_settings++;
			idle_on = (k != 1);
			long_stall_req = (k == 1);
			phase_end = words_sent + 48;
			while (words_sent < phase_end)
				send_random_datagram();
			drain();
		end

		$display("Covered %0d datagrams (%0d accepted) in %0d input words.",
			dgrams, dgrams_ok, words_sent);
		$display("Checked %0d result words over %0d local port settings.",
			words_checked, port_settings);
		if (mismatches == 0 && due_words.size() == 0)
			$display("stop_wait_packet_receiver_core: match");
		else
			$display("stop_wait_packet_receiver_core: mismatch");
		$finish;
	end

endmodule
